[rtl/mmu_tlb_pkg.sv]
// ----------------------------------------------------------------------------
// mmu_tlb_pkg
// Shared constants, codes, types and reset tables of the TLB address
// translator.
// ----------------------------------------------------------------------------
package mmu_tlb_pkg;

	localparam int unsigned PAGE_COUNT_DEF = 8;
	localparam int unsigned TLB_SLOTS_DEF  = 4;
	localparam int unsigned OFFSET_BITS    = 10;
	localparam int unsigned FRAME_BITS     = 4;

	localparam int unsigned KIND_W    = 2;
	localparam int unsigned VA_W      = 16;
	localparam int unsigned VICTIM_W  = 2;
	localparam int unsigned EIDX_W    = 3;
	localparam int unsigned ENTRY_W   = 8;
	localparam int unsigned PA_W      = 14;
	localparam int unsigned STATUS_W  = 3;
	localparam int unsigned PSIZE_W   = 14;
	localparam int unsigned RST_PAGE_W = 6;

	localparam logic [PSIZE_W-1:0] PSIZE_RESET = 14'd7000;

	localparam int unsigned VALID_POS = 4;
	localparam int unsigned ACC_POS   = 5;
	localparam int unsigned DIRTY_POS = 6;

	localparam logic [KIND_W-1:0] KIND_XLATE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REFRESH = 2'd2;

	localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_WALKED   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FRAGMENT = 3'd4;
	localparam logic [STATUS_W-1:0] ST_DONE     = 3'd5;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

	function automatic logic [ENTRY_W-1:0] page_reset_val(input int unsigned idx);
		logic [ENTRY_W-1:0] val;
		unique case (idx)
			0: val = 8'h0C;
			1: val = 8'h08;
			2: val = 8'h05;
			3: val = 8'h0A;
			4: val = 8'h0F;
			5: val = 8'h00;
			6: val = 8'h0F;
			7: val = 8'h0F;
			default: val = 8'h00;
		endcase
		return val;
	endfunction

	function automatic logic [RST_PAGE_W-1:0] tlb_reset_page(input int unsigned idx);
		logic [RST_PAGE_W-1:0] val;
		unique case (idx)
			0: val = 6'd0;
			1: val = 6'd1;
			2: val = 6'd2;
			3: val = 6'd0;
			default: val = 6'd0;
		endcase
		return val;
	endfunction

	function automatic logic [ENTRY_W-1:0] tlb_reset_entry(input int unsigned idx);
		logic [ENTRY_W-1:0] val;
		unique case (idx)
			0: val = 8'h1C;
			1: val = 8'h18;
			2: val = 8'h15;
			3: val = 8'h1A;
			default: val = 8'h00;
		endcase
		return val;
	endfunction

endpackage

[rtl/mmu_tlb_address_translator_top.sv]
// ----------------------------------------------------------------------------
// mmu_tlb_address_translator_top
// Virtual to physical address translation through a fully associative TLB
// backed by a small page table, with page entry writes and valid refresh.
//
//   channel   handshake            payload
//   request   start / busy         kind, virtual_address, is_write,
//                                  victim_slot, entry_index, entry_data
//   result    done (1-cycle)       physical_address, status
//   config    cfg_valid/cfg_ready  cfg_data (process size)
//
// A request is captured, then the execute state runs, in which the tlb
// compare, page entry read and table updates happen. done is high in the
// cycle after execute, and a new request can be taken in that same cycle.
// busy is high only during execute. The result is shown for one cycle and
// cannot be held off. Reset loads the page table, the tlb and the process
// size with their initial contents at once.
// ----------------------------------------------------------------------------
module mmu_tlb_address_translator_top #(
	parameter int unsigned PAGE_COUNT = mmu_tlb_pkg::PAGE_COUNT_DEF,
	parameter int unsigned TLB_SLOTS  = mmu_tlb_pkg::TLB_SLOTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [mmu_tlb_pkg::KIND_W-1:0]       kind,
	input  logic [mmu_tlb_pkg::VA_W-1:0]         virtual_address,
	input  logic                                 is_write,
	input  logic [mmu_tlb_pkg::VICTIM_W-1:0]     victim_slot,
	input  logic [mmu_tlb_pkg::EIDX_W-1:0]       entry_index,
	input  logic [mmu_tlb_pkg::ENTRY_W-1:0]      entry_data,
	output logic                                 done,
	output logic [mmu_tlb_pkg::PA_W-1:0]         physical_address,
	output logic [mmu_tlb_pkg::STATUS_W-1:0]     status,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mmu_tlb_pkg::PSIZE_W-1:0]      cfg_data
);

	mmu_tlb_pkg::cmd_t cmd;

	assign cfg_ready = 1'b1;

	mmu_tlb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	mmu_tlb_dp #(
		.PAGE_COUNT (PAGE_COUNT),
		.TLB_SLOTS  (TLB_SLOTS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.kind             (kind),
		.virtual_address  (virtual_address),
		.is_write         (is_write),
		.victim_slot      (victim_slot),
		.entry_index      (entry_index),
		.entry_data       (entry_data),
		.cfg_valid        (cfg_valid & cfg_ready),
		.cfg_data         (cfg_data),
		.physical_address (physical_address),
		.status           (status)
	);

endmodule

[rtl/mmu_tlb_ctrl.sv]
// ----------------------------------------------------------------------------
// mmu_tlb_ctrl
// Request sequencer: captures a request, runs the execute state and raises
// the done strobe with the registered result.
// ----------------------------------------------------------------------------
module mmu_tlb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	output mmu_tlb_pkg::cmd_t  cmd
);

	mmu_tlb_pkg::state_t state_q;
	mmu_tlb_pkg::state_t state_nxt;
	logic                done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmu_tlb_pkg::S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= cmd.exec;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			mmu_tlb_pkg::S_IDLE: begin
				if (start) begin
					state_nxt = mmu_tlb_pkg::S_EXEC;
				end
			end
			mmu_tlb_pkg::S_EXEC: begin
				state_nxt = mmu_tlb_pkg::S_IDLE;
			end
			default: begin
				state_nxt = mmu_tlb_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		busy     = 1'b0;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		unique case (state_q)
			mmu_tlb_pkg::S_IDLE: begin
				cmd.load = start;
			end
			mmu_tlb_pkg::S_EXEC: begin
				busy     = 1'b1;
				cmd.exec = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	assign done = done_q;

`ifndef SYNTHESIS
	a_accept_to_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not enter execute");

	a_busy_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy && done)
		else $error("execute cycle not followed by done strobe");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done strobe without execute cycle");
`endif

endmodule

[rtl/mmu_tlb_dp.sv]
// ----------------------------------------------------------------------------
// mmu_tlb_dp
// Datapath: request registers, page table, TLB, process size register and
// the result registers.
// ----------------------------------------------------------------------------
module mmu_tlb_dp #(
	parameter int unsigned PAGE_COUNT = mmu_tlb_pkg::PAGE_COUNT_DEF,
	parameter int unsigned TLB_SLOTS  = mmu_tlb_pkg::TLB_SLOTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mmu_tlb_pkg::cmd_t                    cmd,
	input  logic [mmu_tlb_pkg::KIND_W-1:0]       kind,
	input  logic [mmu_tlb_pkg::VA_W-1:0]         virtual_address,
	input  logic                                 is_write,
	input  logic [mmu_tlb_pkg::VICTIM_W-1:0]     victim_slot,
	input  logic [mmu_tlb_pkg::EIDX_W-1:0]       entry_index,
	input  logic [mmu_tlb_pkg::ENTRY_W-1:0]      entry_data,
	input  logic                                 cfg_valid,
	input  logic [mmu_tlb_pkg::PSIZE_W-1:0]      cfg_data,
	output logic [mmu_tlb_pkg::PA_W-1:0]         physical_address,
	output logic [mmu_tlb_pkg::STATUS_W-1:0]     status
);

	localparam int unsigned PAGE_W   = $clog2(PAGE_COUNT);
	localparam int unsigned SLOT_W   = (TLB_SLOTS > 1) ? $clog2(TLB_SLOTS) : 1;
	localparam int unsigned VA_LIMIT = PAGE_COUNT << mmu_tlb_pkg::OFFSET_BITS;
	localparam int unsigned VICTIM_STEPS = (1 << mmu_tlb_pkg::VICTIM_W) - 1;
	localparam int unsigned FB = mmu_tlb_pkg::FRAME_BITS;
	localparam int unsigned OB = mmu_tlb_pkg::OFFSET_BITS;

	logic [mmu_tlb_pkg::KIND_W-1:0]    kind_q;
	logic [mmu_tlb_pkg::VA_W-1:0]      vaddr_q;
	logic                              is_write_q;
	logic [mmu_tlb_pkg::VICTIM_W-1:0]  victim_q;
	logic [mmu_tlb_pkg::EIDX_W-1:0]    eidx_q;
	logic [mmu_tlb_pkg::ENTRY_W-1:0]   edata_q;

	logic [mmu_tlb_pkg::ENTRY_W-1:0]   page_q [PAGE_COUNT];
	logic [PAGE_W-1:0]                 tlb_page_q [TLB_SLOTS];
	logic [FB-1:0]                     tlb_frame_q [TLB_SLOTS];
	logic [mmu_tlb_pkg::PSIZE_W-1:0]   psize_q;

	logic [mmu_tlb_pkg::PA_W-1:0]      pa_q;
	logic [mmu_tlb_pkg::STATUS_W-1:0]  status_q;

	logic [PAGE_W-1:0]                 page_idx;
	logic [OB-1:0]                     offset;
	logic                              out_of_range;
	logic                              fragment;
	logic                              hit_any;
	logic [FB-1:0]                     hit_frame;
	logic [mmu_tlb_pkg::ENTRY_W-1:0]   pe;
	logic [mmu_tlb_pkg::ENTRY_W-1:0]   pe_new;
	logic [FB-1:0]                     xl_frame;
	logic [FB+OB-1:0]                  pa_full;
	logic [mmu_tlb_pkg::VICTIM_W-1:0]  victim_mod;
	logic [SLOT_W-1:0]                 victim_idx;
	logic [mmu_tlb_pkg::PSIZE_W-1:0]   limit;
	logic                              do_walk;
	logic                              do_pwrite;
	logic                              do_refresh;
	logic [mmu_tlb_pkg::PA_W-1:0]      res_pa;
	logic [mmu_tlb_pkg::STATUS_W-1:0]  res_status;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q     <= kind;
			vaddr_q    <= virtual_address;
			is_write_q <= is_write;
			victim_q   <= victim_slot;
			eidx_q     <= entry_index;
			edata_q    <= entry_data;
		end
	end

	assign page_idx     = vaddr_q[OB +: PAGE_W];
	assign offset       = vaddr_q[OB-1:0];
	assign out_of_range = 32'(vaddr_q) >= VA_LIMIT;
	assign fragment     = 32'(vaddr_q) >= 32'(psize_q);
	assign pe           = page_q[page_idx];
	assign limit        = psize_q >> OB;

	// lowest matching slot wins
	always_comb begin
		hit_any   = 1'b0;
		hit_frame = '0;
		for (int i = TLB_SLOTS - 1; i >= 0; i--) begin
			if (tlb_page_q[i] == page_idx) begin
				hit_any   = 1'b1;
				hit_frame = tlb_frame_q[i];
			end
		end
	end

	always_comb begin
		pe_new = pe;
		pe_new[mmu_tlb_pkg::ACC_POS] = 1'b1;
		if (is_write_q) begin
			pe_new[mmu_tlb_pkg::DIRTY_POS] = 1'b1;
		end
	end

	// victim slot modulo slot count
	always_comb begin
		victim_mod = victim_q;
		for (int k = 0; k < VICTIM_STEPS; k++) begin
			if (32'(victim_mod) >= TLB_SLOTS) begin
				victim_mod = victim_mod - mmu_tlb_pkg::VICTIM_W'(TLB_SLOTS);
			end
		end
		victim_idx = SLOT_W'(victim_mod);
	end

	assign xl_frame = hit_any ? hit_frame : pe[FB-1:0];
	assign pa_full  = {xl_frame, offset};

	always_comb begin
		res_status = mmu_tlb_pkg::ST_DONE;
		res_pa     = '0;
		do_walk    = 1'b0;
		do_pwrite  = 1'b0;
		do_refresh = 1'b0;
		unique case (kind_q)
			mmu_tlb_pkg::KIND_XLATE: begin
				if (out_of_range) begin
					res_status = mmu_tlb_pkg::ST_RANGE;
				end else if (hit_any) begin
					res_status = mmu_tlb_pkg::ST_HIT;
					res_pa     = mmu_tlb_pkg::PA_W'(pa_full);
				end else if (!pe[mmu_tlb_pkg::VALID_POS]) begin
					res_status = mmu_tlb_pkg::ST_INVALID;
				end else if (fragment) begin
					res_status = mmu_tlb_pkg::ST_FRAGMENT;
				end else begin
					res_status = mmu_tlb_pkg::ST_WALKED;
					res_pa     = mmu_tlb_pkg::PA_W'(pa_full);
					do_walk    = 1'b1;
				end
			end
			mmu_tlb_pkg::KIND_WRITE: begin
				do_pwrite = 32'(eidx_q) < PAGE_COUNT;
			end
			mmu_tlb_pkg::KIND_REFRESH: begin
				do_refresh = 1'b1;
			end
			default: begin
				res_status = mmu_tlb_pkg::ST_DONE;
			end
		endcase
	end

	// page table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PAGE_COUNT; i++) begin
				page_q[i] <= mmu_tlb_pkg::page_reset_val(i);
			end
		end else if (cmd.exec) begin
			if (do_walk) begin
				page_q[page_idx] <= pe_new;
			end
			if (do_pwrite) begin
				page_q[PAGE_W'(eidx_q)] <= edata_q;
			end
			if (do_refresh) begin
				for (int i = 0; i < PAGE_COUNT; i++) begin
					if (mmu_tlb_pkg::PSIZE_W'(i) <= limit) begin
						page_q[i][mmu_tlb_pkg::VALID_POS] <= 1'b1;
					end
				end
			end
		end
	end

	// tlb
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TLB_SLOTS; i++) begin
				tlb_page_q[i]  <= PAGE_W'(mmu_tlb_pkg::tlb_reset_page(i));
				tlb_frame_q[i] <= FB'(mmu_tlb_pkg::tlb_reset_entry(i));
			end
		end else if (cmd.exec && do_walk) begin
			tlb_page_q[victim_idx]  <= page_idx;
			tlb_frame_q[victim_idx] <= pe_new[FB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psize_q <= mmu_tlb_pkg::PSIZE_RESET;
		end else if (cfg_valid) begin
			psize_q <= cfg_data;
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			pa_q     <= res_pa;
			status_q <= res_status;
		end
	end

	assign physical_address = pa_q;
	assign status           = status_q;

`ifndef SYNTHESIS
	a_fault_zero_pa: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.exec) && status_q != mmu_tlb_pkg::ST_HIT
			&& status_q != mmu_tlb_pkg::ST_WALKED |-> pa_q == '0)
		else $error("nonzero address on a fault or done result");

	a_walk_sets_accessed: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.exec) && status_q == mmu_tlb_pkg::ST_WALKED
			|-> page_q[page_idx][mmu_tlb_pkg::ACC_POS] && hit_any)
		else $error("walk did not mark page accessed or fill tlb");

	a_hit_still_present: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.exec) && status_q == mmu_tlb_pkg::ST_HIT |-> hit_any)
		else $error("tlb hit reported without a matching slot");
`endif

endmodule
